FILE: src/bpu_pkg.sv
// Shared types, field positions and operation codes for the byte pointer unit.
// No dependencies; every other file depends on this package.
package bpu_pkg;

  localparam int WORD_BITS  = 36;
  localparam int FIELD_BITS = 6;
  localparam int Y_BITS     = 18;
  localparam int P_LSB      = 30;
  localparam int S_LSB      = 24;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [FIELD_BITS-1:0] field6_t;
  typedef logic [Y_BITS-1:0]     yaddr_t;
  typedef logic [2:0]            op_code_t;

  typedef enum logic [2:0] {
    OP_LDB  = 3'd0,
    OP_DPB  = 3'd1,
    OP_IBP  = 3'd2,
    OP_ILDB = 3'd3,
    OP_IDPB = 3'd4
  } op_t;

  // What an operation does: advance the pointer, load a byte, deposit a byte.
  typedef struct packed {
    logic incr;
    logic load;
    logic dep;
  } ctl_t;

  function automatic ctl_t decode_op(op_code_t code);
    ctl_t c;
    c = '0;
    case (code)
      OP_LDB:  c.load = 1'b1;
      OP_DPB:  c.dep  = 1'b1;
      OP_IBP:  c.incr = 1'b1;
      OP_ILDB: begin
        c.incr = 1'b1;
        c.load = 1'b1;
      end
      OP_IDPB: begin
        c.incr = 1'b1;
        c.dep  = 1'b1;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: src/bpu_if.sv
// Valid/ready channel interfaces for byte pointer requests and results.
// Depends on bpu_pkg for the word and code types.
interface bpu_req_if;
  logic               valid;
  logic               ready;
  bpu_pkg::op_code_t  req_type;
  bpu_pkg::word_t     pointer_word;
  bpu_pkg::word_t     data_word;
  bpu_pkg::word_t     acc_word;

  modport source (output valid, req_type, pointer_word, data_word, acc_word,
                  input ready);
  modport sink   (input valid, req_type, pointer_word, data_word, acc_word,
                  output ready);
endinterface

interface bpu_rsp_if;
  logic           valid;
  logic           ready;
  bpu_pkg::word_t new_pointer;
  logic           pointer_write;
  bpu_pkg::word_t byte_value;
  logic           acc_write;
  bpu_pkg::word_t new_word;
  logic           word_write;

  modport source (output valid, new_pointer, pointer_write, byte_value, acc_write,
                  new_word, word_write, input ready);
  modport sink   (input valid, new_pointer, pointer_write, byte_value, acc_write,
                  new_word, word_write, output ready);
endinterface

FILE: src/bpu_ptr_incr.sv
// Pointer advance: step P down by S, wrap to the next word when it underflows.
// Depends on bpu_pkg.
module bpu_ptr_incr (
  input  bpu_pkg::word_t   pointer_word,
  input  logic             incr,
  output bpu_pkg::word_t   new_pointer,
  output bpu_pkg::field6_t p_eff
);
  import bpu_pkg::*;

  field6_t p;
  field6_t s;
  yaddr_t  y;
  field6_t p_next;
  yaddr_t  y_next;

  always_comb begin
    p = pointer_word[P_LSB +: FIELD_BITS];
    s = pointer_word[S_LSB +: FIELD_BITS];
    y = pointer_word[Y_BITS-1:0];
    if (p >= s) begin
      p_next = p - s;
      y_next = y;
    end else begin
      // wrap: six-bit difference, so oversize S lands modulo 64
      p_next = FIELD_BITS'(WORD_BITS) - s;
      y_next = y + yaddr_t'(1);
    end
    if (incr) begin
      new_pointer = {p_next, pointer_word[P_LSB-1:Y_BITS], y_next};
      p_eff       = p_next;
    end else begin
      new_pointer = pointer_word;
      p_eff       = p;
    end
  end

endmodule

FILE: src/bpu_byte_field.sv
// Byte extract and deposit on a 36-bit word, given position P and size S.
// Depends on bpu_pkg.
module bpu_byte_field (
  input  bpu_pkg::word_t   data_word,
  input  bpu_pkg::word_t   acc_word,
  input  bpu_pkg::field6_t p,
  input  bpu_pkg::field6_t s,
  input  bpu_pkg::ctl_t    ctl,
  output bpu_pkg::word_t   byte_value,
  output bpu_pkg::word_t   new_word
);
  import bpu_pkg::*;

  word_t mask;
  word_t field_mask;
  word_t field_val;

  always_comb begin
    // sizes of a word or more saturate to a full mask
    if (s >= FIELD_BITS'(WORD_BITS)) mask = '1;
    else                            mask = ~({WORD_BITS{1'b1}} << s);
    // bits shifted past bit 35 drop out; P of 36 or more empties the field
    field_mask = mask << p;
    field_val  = (acc_word & mask) << p;
    byte_value = ctl.load ? ((data_word >> p) & mask) : '0;
    new_word   = ctl.dep ? ((data_word & ~field_mask) | field_val) : '0;
  end

endmodule

FILE: src/byte_pointer_unit.sv
// Byte pointer unit: LDB, DPB, IBP, ILDB and IDPB on 36-bit words.
// Depends on bpu_pkg, bpu_if, bpu_ptr_incr and bpu_byte_field.
//
// One request is taken per clock when the result side keeps up, so the
// sustained rate is one transfer per cycle. A request passes from its transfer
// through the input register and then the result register, with the pointer
// advance, mask build and barrel shifts in the logic between them. While a
// finished result waits, a new request is still taken as long as the input
// register is empty; with both registers full the request side stalls, and
// its ready then follows the result side's ready in the same cycle. The
// increment forms advance the pointer first
// (P = P - S, and on underflow P = 36 - S modulo 64 with Y stepping by one,
// 18-bit wrap); the load and deposit then use the advanced P. Codes five to
// seven return the pointer unchanged with every write flag low and the byte
// and word fields zero. There is no state beyond the two registers, no
// configuration and no clearing pass after reset.
module byte_pointer_unit (
  input logic  clk,
  input logic  rst,
  bpu_req_if.sink   req,
  bpu_rsp_if.source rsp
);
  import bpu_pkg::*;

  // input register
  logic     s1_valid;
  op_code_t s1_op;
  word_t    s1_ptr;
  word_t    s1_data;
  word_t    s1_acc;
  logic     s1_adv;

  // result register
  logic  out_valid;
  word_t out_pointer;
  logic  out_pointer_write;
  word_t out_byte;
  logic  out_acc_write;
  word_t out_word;
  logic  out_word_write;

  // between the registers
  ctl_t    ctl;
  word_t   ptr_adv;
  field6_t p_eff;
  word_t   byte_res;
  word_t   word_res;

  // Advance the input register whenever the result register is free or drains.
  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  // Payload holds unless a transfer lands.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_op   <= req.req_type;
      s1_ptr  <= req.pointer_word;
      s1_data <= req.data_word;
      s1_acc  <= req.acc_word;
    end
  end

  assign ctl = decode_op(s1_op);

  bpu_ptr_incr u_ptr_incr (
    .pointer_word (s1_ptr),
    .incr         (ctl.incr),
    .new_pointer  (ptr_adv),
    .p_eff        (p_eff)
  );

  // S is never touched by the advance, so take it from the held pointer.
  bpu_byte_field u_byte_field (
    .data_word  (s1_data),
    .acc_word   (s1_acc),
    .p          (p_eff),
    .s          (s1_ptr[S_LSB +: FIELD_BITS]),
    .ctl        (ctl),
    .byte_value (byte_res),
    .new_word   (word_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pointer       <= ptr_adv;
      out_pointer_write <= ctl.incr;
      out_byte          <= byte_res;
      out_acc_write     <= ctl.load;
      out_word          <= word_res;
      out_word_write    <= ctl.dep;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.new_pointer   = out_pointer;
  assign rsp.pointer_write = out_pointer_write;
  assign rsp.byte_value    = out_byte;
  assign rsp.acc_write     = out_acc_write;
  assign rsp.new_word      = out_word;
  assign rsp.word_write    = out_word_write;

`ifndef SYNTHESIS
  // A transfer always leaves an item in the input register.
  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> s1_valid)
    else $error("accepted request missing from input register");

  // A held item that cannot move keeps its operation code.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_op) && $stable(s1_ptr)))
    else $error("stalled input register changed");

  // Load and deposit never both write.
  a_one_target: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_acc_write && out_word_write))
    else $error("result writes both accumulator and memory");

  // Fields of unused results stay zero.
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_acc_write || out_byte == '0) &&
                   (out_word_write || out_word == '0)))
    else $error("unused result field not zero");

  // Without an advance the pointer comes back as it went in.
  a_ptr_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !ctl.incr) |=> (out_pointer == $past(s1_ptr)))
    else $error("pointer changed without increment");
`endif

endmodule
